### rtl/pc_line_table_decoder_unit_defines.svh
// Assertion macros shared by the decoder's RTL files.
`ifndef PC_LINE_TABLE_DECODER_UNIT_DEFINES_SVH
`define PC_LINE_TABLE_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PCLT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pclt assertion failed");

`define PCLT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pclt assertion failed");

`define PCLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pclt assertion failed");

`else

`define PCLT_ASSERT_ALWAYS(label, cond)
`define PCLT_ASSERT_IMPLIES(label, ante, cons)
`define PCLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/pclt_pkg.sv
// Types and constants of the pc-to-line table decoder.
`timescale 1ns / 1ps

package pclt_pkg;

    localparam logic [7:0] LINE_ADD_LIMIT = 8'd65;
    localparam logic [7:0] LINE_SUB_BASE  = 8'd64;
    localparam logic [7:0] PC_SKIP_BASE   = 8'd129;
    localparam logic [2:0] DELTA_BYTES    = 3'd4;

    localparam int unsigned PC_ADD_W = 10;
    localparam int unsigned PADDR_W  = 4;

    localparam logic        REG_PC_QUANTUM = 1'b0;
    localparam logic        REG_START_PC   = 1'b1;
    localparam logic [2:0]  QUANTUM_RESET  = 3'd4;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       table_start;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] pc_value;
        logic [31:0] line_number;
        logic        line_changed;
    } out_beat_t;

    // One decoded code, handed from the front end to the back end.
    typedef struct packed {
        logic                reload;
        logic                emit;
        logic [31:0]         line_add;
        logic [PC_ADD_W-1:0] pc_add;
    } op_t;

endpackage

### rtl/pclt_front.sv
// Front end: takes table bytes, gathers line deltas and classifies codes.
`timescale 1ns / 1ps
`include "pc_line_table_decoder_unit_defines.svh"

module pclt_front
    import pclt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_beat_t item,
    input  logic [2:0] pc_quantum,
    output logic     op_valid,
    input  logic     op_ready,
    output op_t      op
);

    logic [2:0]  left_reg, left_next;
    logic [23:0] shift_reg, shift_next;
    logic        accept;
    logic [2:0]  left_eff;
    logic [23:0] shift_eff;
    logic [31:0] gathered;
    logic [7:0]  b;
    logic [6:0]  skip_mult;
    logic        emit;

    assign item_ready = op_ready;
    assign accept     = item_valid && item_ready;
    assign b          = item.code_byte;

    // A table start drops any delta that is still being gathered.
    assign left_eff  = item.table_start ? 3'd0 : left_reg;
    assign shift_eff = item.table_start ? 24'd0 : shift_reg;
    assign gathered  = {shift_eff, b};

    always_comb
    begin
        left_next  = left_eff;
        shift_next = shift_eff;
        emit       = 1'b0;
        skip_mult  = 7'd1;
        op.line_add = 32'd0;
        if (left_eff != 3'd0)
        begin
            left_next  = left_eff - 3'd1;
            shift_next = gathered[23:0];
            if (left_eff == 3'd1)
            begin
                emit        = 1'b1;
                op.line_add = gathered;
                shift_next  = 24'd0;
            end
        end
        else if (b == 8'd0)
        begin
            left_next  = DELTA_BYTES;
            shift_next = 24'd0;
        end
        else if (b < LINE_ADD_LIMIT)
        begin
            emit        = 1'b1;
            op.line_add = 32'(b);
        end
        else if (b < PC_SKIP_BASE)
        begin
            emit        = 1'b1;
            op.line_add = 32'(LINE_SUB_BASE) - 32'(b);
        end
        else
        begin
            // The skip plus the regular step is quantum * (b - 128).
            emit      = 1'b1;
            skip_mult = b[6:0];
        end
        op.reload = item.table_start;
        op.emit   = emit;
        op.pc_add = emit ? PC_ADD_W'(pc_quantum) * PC_ADD_W'(skip_mult) : '0;
    end

    assign op_valid = item_valid && (emit || item.table_start);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 3'd0;
            shift_reg <= 24'd0;
        end
        else if (accept)
        begin
            left_reg  <= left_next;
            shift_reg <= shift_next;
        end
    end

    `PCLT_ASSERT_ALWAYS(a_delta_count_bound, left_reg <= DELTA_BYTES)

endmodule

### rtl/pclt_fifo.sv
// Short queue of decoded codes between the front end and the back end.
`timescale 1ns / 1ps
`include "pc_line_table_decoder_unit_defines.svh"

module pclt_fifo
    import pclt_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    op_t              entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `PCLT_ASSERT_ALWAYS(a_fifo_count_bound, count_reg <= CNT_W'(DEPTH))
    `PCLT_ASSERT_NEXT(a_fifo_count_step, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

### rtl/pclt_back.sv
// Back end: keeps the running pc and line and registers each result.
`timescale 1ns / 1ps
`include "pc_line_table_decoder_unit_defines.svh"

module pclt_back
    import pclt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    output logic        op_ready,
    input  op_t         op,
    input  logic [63:0] start_pc,
    output logic        result_valid,
    input  logic        result_ready,
    output out_beat_t   result
);

    logic [63:0] pc_reg, pc_next;
    logic [31:0] line_reg, line_next;
    logic        result_valid_reg;
    out_beat_t   result_reg;
    logic        out_free;
    logic        pop;

    assign out_free = !result_valid_reg || result_ready;
    // A reload with no result never waits on the output register.
    assign op_ready = out_free || !op.emit;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        pc_next   = (op.reload ? start_pc : pc_reg) + 64'(op.pc_add);
        line_next = (op.reload ? 32'd0 : line_reg) + op.line_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= 64'd0;
            line_reg         <= 32'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pc_reg   <= pc_next;
                line_reg <= line_next;
            end
            if (pop && op.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.emit)
        begin
            result_reg.pc_value     <= pc_next;
            result_reg.line_number  <= line_next;
            result_reg.line_changed <= op.line_add != 32'd0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PCLT_ASSERT_IMPLIES(a_no_result_overwrite, pop && op.emit, out_free)

endmodule

### rtl/pc_line_table_decoder_unit.sv
// Top level of the pc-to-line table decoder with its register port.
//
// The block decodes a pc-to-line table one byte per beat. An input beat
// carries code_byte and table_start; table_start reloads the pc from
// start_pc and the line from zero before the byte is decoded. Each
// completed code gives one result beat with the pc, the line and a flag
// that tells whether the line moved. A zero byte opens a four-byte delta,
// so it and the next three bytes give no result.
// Throughput is one byte per cycle while the queue has room. The code
// that a byte completes is registered in the queue and then in the
// result register of the back end, from which its result beat leaves.
// When the receiver stalls, the result register holds, the queue fills
// and item_ready falls once QUEUE_DEPTH codes are waiting.
// Reset clears the pc, line, pending delta and queue, and sets
// pc_quantum to 4 and start_pc to 0. Registers sit on an APB-style port:
// pc_quantum at byte address 0, start_pc at 8; pready is always high.
`timescale 1ns / 1ps

module pc_line_table_decoder_unit
    import pclt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  in_beat_t           item,
    output logic               result_valid,
    input  logic               result_ready,
    output out_beat_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [2:0]  pc_quantum_reg;
    logic [63:0] start_pc_reg;
    logic        cfg_write;
    op_t         front_op, back_op;
    logic        front_valid, front_ready, back_valid, back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_START_PC) ? start_pc_reg : 64'(pc_quantum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_quantum_reg <= QUANTUM_RESET;
            start_pc_reg   <= 64'd0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_PC_QUANTUM)
            begin
                pc_quantum_reg <= pwdata[2:0];
            end
            else
            begin
                start_pc_reg <= pwdata;
            end
        end
    end

    pclt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pc_quantum (pc_quantum_reg),
        .op_valid   (front_valid),
        .op_ready   (front_ready),
        .op         (front_op)
    );

    pclt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    pclt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .op           (back_op),
        .start_pc     (start_pc_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
